@@ design/bfse_pkg.sv @@
package bfse_pkg;

    // Memory depths. Both must be powers of two, so that wrapping is a plain
    // truncation of the address.
    localparam int PROG_DEPTH = 4096;
    localparam int TAPE_DEPTH = 32768;

    localparam int PC_W   = $clog2(PROG_DEPTH);
    localparam int HEAD_W = $clog2(TAPE_DEPTH);

    // Fixed field widths of the stream payload.
    localparam int ADDR_FIELD_W = 12;
    localparam int OPC_W        = 3;
    localparam int ARG_W        = 16;
    localparam int BYTE_W       = 8;
    localparam int WORD_W       = OPC_W + ARG_W;
    localparam int IN_DATA_W    = 48;
    localparam int OUT_DATA_W   = 24;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef enum logic [OPC_W-1:0] {
        OP_OPEN  = 3'd0,
        OP_CLOSE = 3'd1,
        OP_RIGHT = 3'd2,
        OP_LEFT  = 3'd3,
        OP_ADD   = 3'd4,
        OP_GET   = 3'd5,
        OP_PUT   = 3'd6,
        OP_STOP  = 3'd7
    } t_bfse_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_bfse_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;   // write one zero cell of the clearing pass
        logic load;     // write a program word, post the load result
        logic start;    // latch step inputs, issue program and tape reads
        logic exec;     // execute the fetched instruction, post the result
    } t_bfse_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last; // clearing pass is at the last tape cell
        logic out_free; // output register is empty or drains this cycle
    } t_bfse_sts;

endpackage

@@ design/bfse_ram.sv @@
module bfse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bfse_ctrl.sv @@
module bfse_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_kind,
    input  bfse_pkg::t_bfse_sts i_sts,
    output logic                o_s_tready,
    output bfse_pkg::t_bfse_cmd o_cmd
);

    import bfse_pkg::*;

    t_bfse_state r_state;
    t_bfse_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = i_sts.out_free;
                if (i_s_tvalid && i_sts.out_free) begin
                    if (i_s_kind == KIND_STEP) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_EXEC;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

@@ design/bfse_dp.sv @@
module bfse_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bfse_pkg::t_bfse_cmd                 i_cmd,
    input  logic [bfse_pkg::IN_DATA_W-1:0]      i_s_tdata,
    input  logic                                i_m_tready,
    output bfse_pkg::t_bfse_sts                 o_sts,
    output logic                                o_m_tvalid,
    output logic [bfse_pkg::OUT_DATA_W-1:0]     o_m_tdata
);

    import bfse_pkg::*;

    // Input beat fields.
    logic [ADDR_FIELD_W-1:0] load_address;
    logic [OPC_W-1:0]        load_opcode;
    logic [ARG_W-1:0]        load_operand;
    logic                    in_valid;
    logic [BYTE_W-1:0]       in_byte;
    logic                    in_eof;

    assign load_address = i_s_tdata[11:0];
    assign load_opcode  = i_s_tdata[14:12];
    assign load_operand = i_s_tdata[30:15];
    assign in_valid     = i_s_tdata[31];
    assign in_byte      = i_s_tdata[39:32];
    assign in_eof       = i_s_tdata[40];

    // Architectural state.
    logic [PC_W-1:0]   r_pc;
    logic [PC_W-1:0]   n_pc;
    logic [HEAD_W-1:0] r_head;
    logic [HEAD_W-1:0] n_head;
    logic              r_stopped;
    logic              n_stopped;
    logic [HEAD_W-1:0] r_clr_addr;

    // Step inputs held across the fetch cycle.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_eof;

    // Output register.
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_DATA_W-1:0] n_out_data;

    // Memory ports.
    logic [WORD_W-1:0] prog_rdata;
    logic [BYTE_W-1:0] cell_data;
    logic              tape_we;
    logic [HEAD_W-1:0] tape_waddr;
    logic [BYTE_W-1:0] tape_wdata;

    // Execute-cycle decode.
    t_bfse_op          op;
    logic [ARG_W-1:0]  arg;
    logic [PC_W-1:0]   jump_off;
    logic              cell_zero;
    logic              ex_wr;
    logic [BYTE_W-1:0] ex_wdata;
    logic              ex_put;
    logic              ex_taken;
    logic              ex_wait;

    bfse_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PROG_DEPTH)
    ) u_prog_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (PC_W'(load_address)),
        .i_wdata ({load_opcode, load_operand}),
        .i_re    (i_cmd.start),
        .i_raddr (r_pc),
        .o_rdata (prog_rdata)
    );

    bfse_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TAPE_DEPTH)
    ) u_tape_ram (
        .i_clk   (i_clk),
        .i_we    (tape_we),
        .i_waddr (tape_waddr),
        .i_wdata (tape_wdata),
        .i_re    (i_cmd.start),
        .i_raddr (r_head),
        .o_rdata (cell_data)
    );

    assign op        = t_bfse_op'(prog_rdata[WORD_W-1:ARG_W]);
    assign arg       = prog_rdata[ARG_W-1:0];
    assign cell_zero = (cell_data == '0);

    always_comb begin
        n_pc      = r_pc;
        n_head    = r_head;
        n_stopped = r_stopped;
        jump_off  = '0;
        ex_wr     = 1'b0;
        ex_wdata  = cell_data + arg[BYTE_W-1:0];
        ex_put    = 1'b0;
        ex_taken  = 1'b0;
        ex_wait   = 1'b0;
        if (!r_stopped) begin
            unique case (op)
                OP_OPEN: begin
                    if (cell_zero) begin
                        jump_off = PC_W'(arg);
                    end
                    n_pc = r_pc + jump_off + PC_W'(1);
                end
                OP_CLOSE: begin
                    if (!cell_zero) begin
                        jump_off = PC_W'(arg);
                    end
                    n_pc = r_pc - jump_off + PC_W'(1);
                end
                OP_RIGHT: begin
                    n_head = r_head + HEAD_W'(arg);
                    n_pc   = r_pc + PC_W'(1);
                end
                OP_LEFT: begin
                    n_head = r_head - HEAD_W'(arg);
                    n_pc   = r_pc + PC_W'(1);
                end
                OP_ADD: begin
                    ex_wr = 1'b1;
                    n_pc  = r_pc + PC_W'(1);
                end
                OP_GET: begin
                    if (r_in_valid) begin
                        ex_wr    = 1'b1;
                        ex_wdata = r_in_eof ? {BYTE_W{1'b1}} : r_in_byte;
                        ex_taken = 1'b1;
                        n_pc     = r_pc + PC_W'(1);
                    end else begin
                        ex_wait = 1'b1;
                    end
                end
                OP_PUT: begin
                    ex_put = 1'b1;
                    n_pc   = r_pc + PC_W'(1);
                end
                OP_STOP: begin
                    n_stopped = 1'b1;
                end
                default: begin
                    n_stopped = r_stopped;
                end
            endcase
        end
    end

    // The clearing pass owns the tape write port until it finishes.
    always_comb begin
        if (i_cmd.clr_wr) begin
            tape_we    = 1'b1;
            tape_waddr = r_clr_addr;
            tape_wdata = '0;
        end else begin
            tape_we    = i_cmd.exec && ex_wr;
            tape_waddr = r_head;
            tape_wdata = ex_wdata;
        end
    end

    // Result word: out_valid, out_byte, input_taken, waiting_input, halted,
    // program_counter, from the lowest bit up.
    always_comb begin
        if (i_cmd.exec) begin
            n_out_data = {ADDR_FIELD_W'(n_pc), n_stopped, ex_wait, ex_taken,
                          (ex_put ? cell_data : {BYTE_W{1'b0}}), ex_put};
        end else begin
            n_out_data = {ADDR_FIELD_W'(r_pc), r_stopped, 1'b0, 1'b0,
                          {BYTE_W{1'b0}}, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_head      <= HEAD_W'(TAPE_DEPTH / 2);
            r_stopped   <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + HEAD_W'(1);
            end
            if (i_cmd.exec) begin
                r_pc      <= n_pc;
                r_head    <= n_head;
                r_stopped <= n_stopped;
            end
            if (i_cmd.exec || i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_in_valid <= in_valid;
            r_in_byte  <= in_byte;
            r_in_eof   <= in_eof;
        end
        if (i_cmd.exec || i_cmd.load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_sts.clr_last = (r_clr_addr == HEAD_W'(TAPE_DEPTH - 1));
    assign o_sts.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid     = r_out_valid;
    assign o_m_tdata      = r_out_data;

endmodule

@@ design/brainfuck_step_executor_unit.sv @@
// Step engine for run-length Brainfuck code. Each input beat is either a
// load (tuser = 0), which writes one opcode/operand word into the program
// memory, or a step (tuser = 1), which executes the instruction at the
// program counter against the tape cell under the head. Every beat yields
// exactly one result beat carrying any output byte, the input handshake
// flags, the halt flag and the program counter after the beat. After reset
// the block sweeps the whole tape to zero, one cell per clock, and input
// tready stays low until the last cell is cleared. A load writes its word
// and registers its result in the cycle it is accepted; a step first reads
// the program word and the tape cell from their synchronous memories, then
// in the execute state decodes it, writes the cell back and posts the
// result. Only one beat is in flight at a time, and a new beat is taken
// once the result register is empty or is being drained in that cycle.
// Program and tape addresses wrap at their memory depths.
module brainfuck_step_executor_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // load_address, load_opcode, load_operand, in_valid, in_byte, in_eof,
    // from the lowest bit up; bits 47:41 are zero padding.
    input  logic [bfse_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // kind: 0 load a program word, 1 execute one step.
    input  logic                                s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_valid, out_byte, input_taken, waiting_input, halted,
    // program_counter, from the lowest bit up.
    output logic [bfse_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    import bfse_pkg::*;

    t_bfse_cmd cmd;
    t_bfse_sts sts;
    logic      s_beat;

    bfse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_kind   (s_axis_tuser),
        .i_sts      (sts),
        .o_s_tready (s_axis_tready),
        .o_cmd      (cmd)
    );

    bfse_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_s_tdata  (s_axis_tdata),
        .i_m_tready (m_axis_tready),
        .o_sts      (sts),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata)
    );

    assign s_beat = s_axis_tvalid && s_axis_tready;

    // A step holds the engine for its execute cycle, so no beat can follow
    // directly behind it.
    a_step_blocks_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat && (s_axis_tuser == KIND_STEP) |=> !s_axis_tready)
        else $error("input beat accepted during the execute cycle of a step");

    // Execution always follows the fetch cycle of an accepted step.
    a_exec_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |-> $past(cmd.start))
        else $error("execute issued without a preceding fetch");

    // A fresh result is registered from a load itself, or from the execute state that follows a step's fetch.
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) && $past(i_rst_n) |-> $past(s_beat) || $past(s_beat, 2))
        else $error("result beat without an accepted input beat");

    // The controller issues at most one datapath command per cycle.
    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr_wr, cmd.load, cmd.start, cmd.exec}))
        else $error("overlapping datapath commands");

endmodule
